/* src/fbps_pkg.sv */
// ----------------------------------------------------------------------------
// Fan burst PWM scheduler package
// Beat types, register indexes, microcode format and the microprogram ROM.
// ----------------------------------------------------------------------------
package fbps_pkg;

  typedef struct packed {
    logic [15:0] demand;
    logic        stall_warning;
  } in_beat_t;

  typedef struct packed {
    logic [9:0]  pulse_level;
    logic [13:0] pulse_ms;
    logic [9:0]  run_level;
    logic [15:0] run_ms;
    logic [15:0] gap_ms;
  } out_beat_t;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_PERIOD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_START     = 2'd3;

  localparam logic [9:0]  LEVEL_MAX = 10'd1023;
  localparam logic [13:0] CARRY_MAX = 14'd16383;
  localparam logic [9:0]  MS_PER_S  = 10'd1000;

  localparam int unsigned QUOT_W = 31;
  localparam int unsigned DIVR_W = 16;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_PERIOD,
    OP_PULSE,
    OP_MUL,
    OP_AREA,
    OP_DIV_TL,
    OP_DIV_MRS,
    OP_BURST,
    OP_RUNFULL,
    OP_HIGH,
    OP_LOW_ENERGY,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_DIV_BUSY,
    C_OUT_BUSY,
    C_HIGH,
    C_ENERGY_LOW,
    C_DENS_GT
  } cond_t;

  localparam int unsigned STEP_W = 4;

  localparam logic [STEP_W-1:0] STEP_LOAD     = 4'd0;
  localparam logic [STEP_W-1:0] STEP_PERIOD   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_PULSE    = 4'd2;
  localparam logic [STEP_W-1:0] STEP_MUL      = 4'd3;
  localparam logic [STEP_W-1:0] STEP_CHK      = 4'd4;
  localparam logic [STEP_W-1:0] STEP_AREA     = 4'd5;
  localparam logic [STEP_W-1:0] STEP_DIV_TL   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_WAIT_TL  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_DIV_MRS  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_WAIT_MRS = 4'd9;
  localparam logic [STEP_W-1:0] STEP_BURST    = 4'd10;
  localparam logic [STEP_W-1:0] STEP_RUNFULL  = 4'd11;
  localparam logic [STEP_W-1:0] STEP_HIGH     = 4'd12;
  localparam logic [STEP_W-1:0] STEP_LOW_EN   = 4'd13;
  localparam logic [STEP_W-1:0] STEP_OUT      = 4'd14;

  typedef struct packed {
    op_t               op;
    cond_t             wait_c;
    cond_t             jmp_c;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    op_t  op;
    logic exec;
  } ctrl_t;

  typedef struct packed {
    logic no_in;
    logic div_busy;
    logic out_busy;
    logic high;
    logic energy_low;
    logic dens_gt;
  } flags_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t uw;
    uw = '{op: OP_NOP, wait_c: C_NEVER, jmp_c: C_ALWAYS, target: STEP_LOAD};
    case (step)
      STEP_LOAD:     uw = '{OP_LOAD,       C_NO_IN,    C_NEVER,      STEP_LOAD};
      STEP_PERIOD:   uw = '{OP_PERIOD,     C_NEVER,    C_HIGH,       STEP_HIGH};
      STEP_PULSE:    uw = '{OP_PULSE,      C_NEVER,    C_NEVER,      STEP_LOAD};
      STEP_MUL:      uw = '{OP_MUL,        C_NEVER,    C_NEVER,      STEP_LOAD};
      STEP_CHK:      uw = '{OP_NOP,        C_NEVER,    C_ENERGY_LOW, STEP_LOW_EN};
      STEP_AREA:     uw = '{OP_AREA,       C_NEVER,    C_NEVER,      STEP_LOAD};
      STEP_DIV_TL:   uw = '{OP_DIV_TL,     C_NEVER,    C_NEVER,      STEP_LOAD};
      STEP_WAIT_TL:  uw = '{OP_NOP,        C_DIV_BUSY, C_DENS_GT,    STEP_RUNFULL};
      STEP_DIV_MRS:  uw = '{OP_DIV_MRS,    C_NEVER,    C_NEVER,      STEP_LOAD};
      STEP_WAIT_MRS: uw = '{OP_NOP,        C_DIV_BUSY, C_NEVER,      STEP_LOAD};
      STEP_BURST:    uw = '{OP_BURST,      C_NEVER,    C_ALWAYS,     STEP_OUT};
      STEP_RUNFULL:  uw = '{OP_RUNFULL,    C_NEVER,    C_ALWAYS,     STEP_OUT};
      STEP_HIGH:     uw = '{OP_HIGH,       C_NEVER,    C_ALWAYS,     STEP_OUT};
      STEP_LOW_EN:   uw = '{OP_LOW_ENERGY, C_NEVER,    C_NEVER,      STEP_LOAD};
      STEP_OUT:      uw = '{OP_OUT,        C_OUT_BUSY, C_ALWAYS,     STEP_LOAD};
      default:       uw = '{OP_NOP,        C_NEVER,    C_ALWAYS,     STEP_LOAD};
    endcase
    return uw;
  endfunction

  function automatic logic [9:0] sat_level(input logic [QUOT_W-1:0] v);
    return (v > QUOT_W'(LEVEL_MAX)) ? LEVEL_MAX : v[9:0];
  endfunction

endpackage

/* src/fbps_div.sv */
// ----------------------------------------------------------------------------
// Fan burst PWM scheduler divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fbps_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [fbps_pkg::QUOT_W-1:0]     dividend,
  input  logic [fbps_pkg::DIVR_W-1:0]     divisor,
  output logic                            busy,
  output logic [fbps_pkg::QUOT_W-1:0]     quotient
);

  localparam int unsigned QW = fbps_pkg::QUOT_W;
  localparam int unsigned DW = fbps_pkg::DIVR_W;
  localparam int unsigned CW = $clog2(QW);

  logic [QW-1:0] q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;

  always_comb begin
    rem_sh = {rem_r, q_r[QW-1]};
    diff   = rem_sh - {1'b0, dvs_r};
    if (rem_sh >= {1'b0, dvs_r}) begin
      rem_nxt = diff[DW-1:0];
      q_nxt   = {q_r[QW-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[DW-1:0];
      q_nxt   = {q_r[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(QW - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

/* src/fbps_seq.sv */
// ----------------------------------------------------------------------------
// Fan burst PWM scheduler sequencer
// Step counter over the microprogram ROM with wait and jump conditions.
// ----------------------------------------------------------------------------
module fbps_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  fbps_pkg::flags_t flags,
  output fbps_pkg::ctrl_t  ctrl
);

  logic [fbps_pkg::STEP_W-1:0] pc_r, pc_nxt;
  fbps_pkg::ucode_t            uw;
  logic                        waiting;
  logic                        taken;

  function automatic logic cond_eval(input fbps_pkg::cond_t c, input fbps_pkg::flags_t f);
    logic r;
    r = 1'b0;
    unique case (c)
      fbps_pkg::C_NEVER:      r = 1'b0;
      fbps_pkg::C_ALWAYS:     r = 1'b1;
      fbps_pkg::C_NO_IN:      r = f.no_in;
      fbps_pkg::C_DIV_BUSY:   r = f.div_busy;
      fbps_pkg::C_OUT_BUSY:   r = f.out_busy;
      fbps_pkg::C_HIGH:       r = f.high;
      fbps_pkg::C_ENERGY_LOW: r = f.energy_low;
      fbps_pkg::C_DENS_GT:    r = f.dens_gt;
      default:                r = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    uw      = fbps_pkg::ucode_rom(pc_r);
    waiting = cond_eval(uw.wait_c, flags);
    taken   = cond_eval(uw.jmp_c, flags);
    if (waiting) begin
      pc_nxt = pc_r;
    end else if (taken) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
    ctrl.op   = uw.op;
    ctrl.exec = !waiting;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= fbps_pkg::STEP_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

/* src/fbps_dp.sv */
// ----------------------------------------------------------------------------
// Fan burst PWM scheduler datapath
// Configuration registers, schedule arithmetic, scan state and result register.
// ----------------------------------------------------------------------------
module fbps_dp #(
  parameter int unsigned DEMAND_RANGE = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [fbps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbps_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  input  fbps_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fbps_pkg::out_beat_t                 out_data,
  input  fbps_pkg::ctrl_t                     ctrl,
  output fbps_pkg::flags_t                    flags,
  output logic                                div_start,
  output logic [fbps_pkg::QUOT_W-1:0]         div_dividend,
  output logic [fbps_pkg::DIVR_W-1:0]         div_divisor,
  input  logic                                div_busy,
  input  logic [fbps_pkg::QUOT_W-1:0]         div_quot
);

  localparam logic [16:0] DEMAND_MAX = 17'(DEMAND_RANGE - 1);
  localparam int unsigned QW = fbps_pkg::QUOT_W;

  logic [5:0]  per_s_r;
  logic [13:0] pulse_cfg_r;
  logic [9:0]  mrs_r;
  logic [9:0]  mss_r;

  logic [15:0] d_r;
  logic        stall_r;
  logic [15:0] period_r;
  logic [14:0] sum_r;
  logic [9:0]  pl_r;
  logic [13:0] pms_r;
  logic [QW-1:0] energy_r;
  logic [23:0] pe_r;
  logic [15:0] tl_r;
  logic [QW-1:0] area_r;
  logic [9:0]  rl_r;
  logic [15:0] rms_r;
  logic [15:0] gms_r;
  logic [13:0] carry_r;
  logic        gap_r;
  logic        out_valid_r;
  fbps_pkg::out_beat_t out_r;

  logic [5:0]  secs;
  logic [9:0]  mrs_eff;
  logic [15:0] period_m1;
  logic [15:0] on_ms;
  logic        run;

  assign run       = ctrl.exec;
  assign secs      = (per_s_r == '0) ? 6'd1 : per_s_r;
  assign mrs_eff   = (mrs_r == '0) ? 10'd1 : mrs_r;
  assign period_m1 = period_r - 16'd1;
  assign on_ms     = (div_quot > QW'(tl_r)) ? tl_r : div_quot[15:0];

  assign flags.no_in      = !in_valid;
  assign flags.div_busy   = div_busy;
  assign flags.out_busy   = out_valid_r && out_stall;
  assign flags.high       = d_r > {6'd0, mss_r};
  assign flags.energy_low = energy_r < QW'(pe_r);
  assign flags.dens_gt    = div_quot > QW'(mrs_eff);

  assign div_start    = run && (ctrl.op == fbps_pkg::OP_DIV_TL || ctrl.op == fbps_pkg::OP_DIV_MRS);
  assign div_dividend = area_r;
  assign div_divisor  = (ctrl.op == fbps_pkg::OP_DIV_TL) ? tl_r : {6'd0, mrs_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      per_s_r     <= 6'd20;
      pulse_cfg_r <= 14'd800;
      mrs_r       <= 10'd100;
      mss_r       <= 10'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        fbps_pkg::REG_OUTPUT_PERIOD: per_s_r     <= cfg_wdata[5:0];
        fbps_pkg::REG_PULSE_PERIOD:  pulse_cfg_r <= cfg_wdata;
        fbps_pkg::REG_MIN_RUN:       mrs_r       <= cfg_wdata[9:0];
        fbps_pkg::REG_MIN_START:     mss_r       <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r     <= '0;
      gap_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (run && ctrl.op == fbps_pkg::OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (run) begin
        case (ctrl.op) inside
          fbps_pkg::OP_BURST, fbps_pkg::OP_RUNFULL, fbps_pkg::OP_HIGH: begin
            carry_r <= '0;
          end
          fbps_pkg::OP_LOW_ENERGY: begin
            carry_r <= (sum_r > {1'b0, fbps_pkg::CARRY_MAX}) ? fbps_pkg::CARRY_MAX
                                                              : sum_r[13:0];
          end
          fbps_pkg::OP_OUT: begin
            gap_r <= gms_r != '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      case (ctrl.op)
        fbps_pkg::OP_LOAD: begin
          d_r     <= ({1'b0, in_data.demand} > DEMAND_MAX) ? DEMAND_MAX[15:0]
                                                           : in_data.demand;
          stall_r <= in_data.stall_warning;
        end
        fbps_pkg::OP_PERIOD: begin
          period_r <= {10'd0, secs} * {6'd0, fbps_pkg::MS_PER_S};
          sum_r    <= {5'd0, d_r[9:0]} + {1'b0, carry_r};
        end
        fbps_pkg::OP_PULSE: begin
          if (gap_r || stall_r) begin
            pms_r <= ({2'd0, pulse_cfg_r} < period_m1) ? pulse_cfg_r : period_m1[13:0];
            pl_r  <= mss_r;
          end else begin
            pms_r <= '0;
            pl_r  <= '0;
          end
        end
        fbps_pkg::OP_MUL: begin
          energy_r <= {16'd0, sum_r} * {15'd0, period_r};
          pe_r     <= pl_r * pms_r;
          tl_r     <= period_r - {2'd0, pms_r};
        end
        fbps_pkg::OP_AREA: begin
          area_r <= energy_r - QW'(pe_r);
        end
        fbps_pkg::OP_RUNFULL: begin
          rl_r  <= fbps_pkg::sat_level(div_quot);
          rms_r <= tl_r;
          gms_r <= '0;
        end
        fbps_pkg::OP_BURST: begin
          rl_r  <= mrs_eff;
          rms_r <= on_ms;
          gms_r <= tl_r - on_ms;
        end
        fbps_pkg::OP_HIGH: begin
          pl_r  <= '0;
          pms_r <= '0;
          rl_r  <= fbps_pkg::sat_level(QW'(d_r));
          rms_r <= period_r;
          gms_r <= '0;
        end
        fbps_pkg::OP_LOW_ENERGY: begin
          pl_r  <= '0;
          pms_r <= '0;
          rl_r  <= '0;
          rms_r <= '0;
          gms_r <= period_r;
        end
        fbps_pkg::OP_OUT: begin
          out_r <= '{pulse_level: pl_r, pulse_ms: pms_r, run_level: rl_r,
                     run_ms: rms_r, gap_ms: gms_r};
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* src/fan_burst_pwm_scheduler_top.sv */
// ----------------------------------------------------------------------------
// Fan burst PWM scheduler
// Turns one fan demand beat per scan into a pulse, run and gap schedule.
// ----------------------------------------------------------------------------
// One input beat is taken at a time and one result beat comes back for it.
// The result beat is offered soonest when the demand is above the start
// speed, and next soonest when the energy falls below the pulse energy.
// Otherwise the density is found by the divider, which works through the
// quotient bits in turn; a minimum-speed burst needs a second pass of the
// same divider. The next input beat can be taken in the cycle after the
// result is loaded into the output register, even while that result still
// waits to be taken.
// A result that is still waiting holds the next one back until it is taken.
module fan_burst_pwm_scheduler_top #(
  parameter int unsigned DEMAND_RANGE = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fbps_pkg::in_beat_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fbps_pkg::out_beat_t             out_data
);

  fbps_pkg::ctrl_t                 ctrl;
  fbps_pkg::flags_t                flags;
  logic                            div_start;
  logic [fbps_pkg::QUOT_W-1:0]     div_dividend;
  logic [fbps_pkg::DIVR_W-1:0]     div_divisor;
  logic                            div_busy;
  logic [fbps_pkg::QUOT_W-1:0]     div_quot;

  assign in_stall = ctrl.op != fbps_pkg::OP_LOAD;

  fbps_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  fbps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  fbps_dp #(
    .DEMAND_RANGE (DEMAND_RANGE)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .ctrl         (ctrl),
    .flags        (flags),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_busy     (div_busy),
    .div_quot     (div_quot)
  );

endmodule

/* test/fan_schedule_checker.sv */
// ----------------------------------------------------------------------------
// Fan schedule checker
// Watches the register port and both beat channels of the fan burst PWM
// scheduler. Each accepted demand beat is turned into the expected pulse, run
// and gap schedule by an independent model of the scan arithmetic, and each
// result beat is compared field by field with the oldest expected schedule.
// ----------------------------------------------------------------------------
module fan_schedule_checker #(
  parameter int unsigned DEMAND_RANGE = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  fbps_pkg::in_beat_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  fbps_pkg::out_beat_t             out_data,
  output int                              mismatches,
  output int                              pending
);

  logic [5:0]  period_s;
  logic [13:0] pulse_len;
  logic [9:0]  run_floor;
  logic [9:0]  start_lvl;
  logic [13:0] carry_dem;
  logic        gap_prev;
  fbps_pkg::out_beat_t sched_q[$];
  int          fail_cnt = 0;

  function automatic fbps_pkg::out_beat_t plan_scan(input fbps_pkg::in_beat_t beat);
    longint unsigned dem, period, p_lvl, p_ms, r_lvl, r_ms, g_ms;
    longint unsigned energy, p_energy, t_left, area, dens, mrs, on_ms, carry;
    fbps_pkg::out_beat_t res;
    dem = beat.demand;
    if (dem > DEMAND_RANGE - 1) dem = DEMAND_RANGE - 1;
    period = ((period_s == 0) ? 1 : period_s) * 1000;
    p_lvl = 0;
    p_ms = 0;
    r_lvl = 0;
    r_ms = 0;
    g_ms = 0;
    if (dem > start_lvl) begin
      r_lvl = (dem > fbps_pkg::LEVEL_MAX) ? fbps_pkg::LEVEL_MAX : dem;
      r_ms = period;
      carry_dem = '0;
    end else begin
      if (gap_prev || beat.stall_warning) begin
        p_ms = (pulse_len < period - 1) ? pulse_len : period - 1;
        p_lvl = start_lvl;
      end
      energy = (dem + carry_dem) * period;
      p_energy = p_lvl * p_ms;
      t_left = period - p_ms;
      if (energy < p_energy) begin
        p_lvl = 0;
        p_ms = 0;
        g_ms = period;
        carry = carry_dem + dem;
        carry_dem = (carry > fbps_pkg::CARRY_MAX) ? fbps_pkg::CARRY_MAX : 14'(carry);
      end else begin
        area = energy - p_energy;
        dens = area / t_left;
        mrs = (run_floor == 0) ? 1 : run_floor;
        if (dens > mrs) begin
          r_lvl = (dens > fbps_pkg::LEVEL_MAX) ? fbps_pkg::LEVEL_MAX : dens;
          r_ms = t_left;
        end else begin
          on_ms = area / mrs;
          if (on_ms > t_left) on_ms = t_left;
          r_lvl = mrs;
          r_ms = on_ms;
          g_ms = t_left - on_ms;
        end
        carry_dem = '0;
      end
    end
    gap_prev = (g_ms != 0);
    res.pulse_level = 10'(p_lvl);
    res.pulse_ms = 14'(p_ms);
    res.run_level = 10'(r_lvl);
    res.run_ms = 16'(r_ms);
    res.gap_ms = 16'(g_ms);
    return res;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    fbps_pkg::out_beat_t want;
    if (!rst_n) begin
      period_s = 6'd20;
      pulse_len = 14'd800;
      run_floor = 10'd100;
      start_lvl = 10'd512;
      carry_dem = '0;
      gap_prev = 1'b0;
      sched_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fbps_pkg::REG_OUTPUT_PERIOD: period_s = cfg_wdata[5:0];
          fbps_pkg::REG_PULSE_PERIOD:  pulse_len = cfg_wdata[13:0];
          fbps_pkg::REG_MIN_RUN:       run_floor = cfg_wdata[9:0];
          fbps_pkg::REG_MIN_START:     start_lvl = cfg_wdata[9:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) sched_q.push_back(plan_scan(in_data));
      if (out_valid && !out_stall) begin
        if (sched_q.size() == 0) begin
          $error("Result beat arrived with no schedule expected.");
          fail_cnt++;
        end else begin
          want = sched_q.pop_front();
          check_field("pulse_level", want.pulse_level, out_data.pulse_level);
          check_field("pulse_ms", want.pulse_ms, out_data.pulse_ms);
          check_field("run_level", want.run_level, out_data.run_level);
          check_field("run_ms", want.run_ms, out_data.run_ms);
          check_field("gap_ms", want.gap_ms, out_data.gap_ms);
        end
      end
    end
    pending <= sched_q.size();
    mismatches <= fail_cnt;
  end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// Fan burst PWM scheduler testbench
// Drives demand beats and register settings into the scheduler with random
// gaps and output stalls. A directed opening covers field extremes and the
// corner cases of the scan arithmetic, then random phases under several
// register settings follow. The checker reports mismatches; this top gives
// the verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned DEMAND_RANGE = 1024;
  localparam int LIMIT = 2000000;
  localparam int HOLD_CYCLES = 400;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [fbps_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fbps_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                            in_valid;
  logic                            in_stall;
  fbps_pkg::in_beat_t              in_data;
  logic                            out_valid;
  logic                            out_stall;
  fbps_pkg::out_beat_t             out_data;
  int                              mismatches;
  int                              pending;
  int                              cycle_count = 0;
  bit                              calm = 1'b0;
  bit                              hold_req = 1'b0;
  int unsigned                     cur_run = 100;
  int unsigned                     cur_start = 512;

  fan_burst_pwm_scheduler_top #(.DEMAND_RANGE(DEMAND_RANGE)) i_dut (.*);

  fan_schedule_checker #(.DEMAND_RANGE(DEMAND_RANGE)) i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [15:0] pick_demand();
    int r;
    int unsigned lo;
    r = $urandom_range(0, 99);
    lo = (cur_start > 40) ? cur_start - 40 : 0;
    if (r < 30) return 16'($urandom_range(lo, cur_start + 40));
    if (r < 55) return 16'($urandom_range(0, cur_run * 2 + 4));
    if (r < 70) return 16'($urandom_range(0, 65535));
    if (r < 78) return 16'd0;
    if (r < 86) begin
      case ($urandom_range(0, 2))
        0:       return 16'd1023;
        1:       return 16'd1024;
        default: return 16'hFFFF;
      endcase
    end
    return 16'($urandom_range(0, 1023));
  endfunction

  initial begin : drain_side
    int run;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        run = idle_len() + 1;
        out_stall <= ($urandom_range(0, 99) < 35);
        repeat (run - 1) @(posedge clk);
      end
    end
  end

  task automatic send_scan(input logic [15:0] dem, input logic stl);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{demand: dem, stall_warning: stl};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic scan_run(input int count);
    repeat (count) send_scan(pick_demand(), $urandom_range(0, 3) == 0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fbps_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[fbps_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  task automatic apply_setting(input int unsigned secs, input int unsigned pulse,
                               input int unsigned run, input int unsigned start);
    wait_idle();
    write_reg(fbps_pkg::REG_OUTPUT_PERIOD, secs);
    write_reg(fbps_pkg::REG_PULSE_PERIOD, pulse);
    write_reg(fbps_pkg::REG_MIN_RUN, run);
    write_reg(fbps_pkg::REG_MIN_START, start);
    cfg_we <= 1'b0;
    cur_run = run;
    cur_start = start;
  endtask

  task automatic random_setting();
    int unsigned s, p, r, st;
    case ($urandom_range(0, 3))
      0:       s = 0;
      1:       s = 1;
      2:       s = 63;
      default: s = $urandom_range(1, 60);
    endcase
    case ($urandom_range(0, 3))
      0:       p = 0;
      1:       p = 16383;
      2:       p = $urandom_range(0, 16383);
      default: p = $urandom_range(0, 3000);
    endcase
    case ($urandom_range(0, 3))
      0:       r = 0;
      1:       r = 1;
      2:       r = 1023;
      default: r = $urandom_range(1, 400);
    endcase
    case ($urandom_range(0, 2))
      0:       st = 0;
      1:       st = 1023;
      default: st = $urandom_range(0, 1023);
    endcase
    apply_setting(s, p, r, st);
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    send_scan(16'd0, 1'b0);
    send_scan(16'hFFFF, 1'b0);
    send_scan(16'd1023, 1'b0);
    send_scan(16'd512, 1'b0);
    send_scan(16'd513, 1'b0);
    send_scan(16'd1024, 1'b1);
    send_scan(16'd10, 1'b1);
    send_scan(16'd10, 1'b0);
    send_scan(16'd300, 1'b0);
    send_scan(16'd50, 1'b1);
    send_scan(16'd0, 1'b0);

    apply_setting(1, 16383, 1023, 1023);
    send_scan(16'd500, 1'b1);
    send_scan(16'd1000, 1'b0);
    send_scan(16'd1023, 1'b0);
    send_scan(16'd0, 1'b1);
    send_scan(16'hFFFF, 1'b1);

    apply_setting(0, 5000, 0, 0);
    send_scan(16'd0, 1'b1);
    send_scan(16'd1, 1'b0);
    send_scan(16'd0, 1'b0);

    apply_setting(1, 1, 1, 1023);
    send_scan(16'd3, 1'b1);
    send_scan(16'd3, 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) apply_setting(20, 800, 100, 512);
      else random_setting();
      calm = (ph == 2);
      if (ph == 4) begin
        in_valid <= 1'b0;
        hold_req = 1'b1;
        do @(posedge clk); while (hold_req);
        calm = 1'b1;
        scan_run(30);
        calm = 1'b0;
      end
      scan_run(85);
    end
    calm = 1'b0;

    wait_idle();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
